// ===== hw/rtl/soft_binned_histogram_sampler_macros.svh =====
// Assertion macros shared by the histogram sampler RTL.
// Stand-alone header; include guard only, no other dependencies.
`ifndef SOFT_BINNED_HISTOGRAM_SAMPLER_MACROS_SVH
`define SOFT_BINNED_HISTOGRAM_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SBHS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SBHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sbhs_pkg.sv =====
// Shared widths, function codes, constants and controller/datapath structs
// for the histogram sampler. No dependencies.
`default_nettype none

package sbhs_pkg;

   localparam int FUNC_W       = 2;
   localparam int VALUE_W      = 16;
   localparam int BIN_OUT_W    = 4;
   localparam int WEIGHT_W     = 40;
   localparam int TOTAL_W      = 44;
   localparam int TOTAL_SPLIT  = 22;
   localparam int BINS_DEFAULT = 12;

   localparam logic [FUNC_W-1:0] FUNC_OBSERVE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DRAW    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

   localparam logic [VALUE_W-1:0] OBS_CLAMP    = 16'd65529;
   localparam logic [VALUE_W-1:0] SAMPLE_CLAMP = 16'd64880;
   localparam logic [VALUE_W-1:0] HALF_Q16     = 16'd32768;
   localparam logic [VALUE_W:0]   ONE_Q16      = 17'd65536;

   typedef struct packed {
      logic capture;
      logic obs_calc;
      logic rd_main;
      logic wr_main;
      logic rd_nbr;
      logic wr_nbr;
      logic clear;
      logic mul_lo;
      logic mul_hi;
      logic tgt;
      logic walk_step;
      logic div0;
      logic div1;
      logic div2;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic walk_more;
   } sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/soft_binned_histogram_sampler.sv =====
// Top level of the histogram sampler: sequencer plus datapath.
// Depends on sbhs_pkg, sbhs_ctrl, sbhs_dp and the assertion macro header.
//
//   Channel | Direction | Handshake                  | Payload
//   --------+-----------+----------------------------+------------------------------------
//   req     | in        | req_valid / req_ready      | func, obs_value, rand_pick, rand_place
//   rsp     | out       | rsp_valid / rsp_ready      | sample, sample_bin
//
// A draw takes longer the higher its chosen bin: it walks the weight memory
// one bin per cycle through its single read port. An observation is two
// read-modify-writes on that port.
// Reset clears the state, the result valid flag and the per-bin valid bits, and
// loads the total; no memory sweep follows, so a transaction can enter at once.
// A finished result waits in the output register; the next transaction is taken
// meanwhile and stalls only at its own end until that register is free.
`default_nettype none
`include "soft_binned_histogram_sampler_macros.svh"

module soft_binned_histogram_sampler #(
   parameter int BINS = sbhs_pkg::BINS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [sbhs_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [sbhs_pkg::VALUE_W-1:0]     req_obs_value,
   input  wire logic [sbhs_pkg::VALUE_W-1:0]     req_rand_pick,
   input  wire logic [sbhs_pkg::VALUE_W-1:0]     req_rand_place,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [sbhs_pkg::VALUE_W-1:0]          rsp_sample,
   output logic [sbhs_pkg::BIN_OUT_W-1:0]        rsp_sample_bin
);

   sbhs_pkg::cmd_type cmd;
   sbhs_pkg::sts_type sts;

   // sequencer: owns the state, the input ready and the result valid flag
   sbhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: weight memory with valid bits, total, draw walk, placement, result
   sbhs_dp #(
      .BINS (BINS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_obs_value  (req_obs_value),
      .req_rand_pick  (req_rand_pick),
      .req_rand_place (req_rand_place),
      .rsp_sample     (rsp_sample),
      .rsp_sample_bin (rsp_sample_bin)
   );

   // never overwrite a result that is still waiting
   `SBHS_ASSERT_IMPL(a_load_free, clock, reset, cmd.load_rsp, (!rsp_valid || rsp_ready), "result overwritten")
   // a taken transaction makes the block busy on the next cycle
   `SBHS_ASSERT_NEXT(a_busy_after_take, clock, reset, (req_valid && req_ready), !req_ready, "ready after accept")
   // at most one writer of the weight store or capture per cycle
   `SBHS_ASSERT_IMPL(a_one_writer, clock, reset, 1'b1, $onehot0({cmd.wr_main, cmd.wr_nbr, cmd.clear, cmd.capture}), "write conflict")

endmodule

`default_nettype wire

// ===== hw/rtl/sbhs_ctrl.sv =====
// Sequencer for the histogram sampler: dispatches each transaction and
// steps the datapath. Depends on sbhs_pkg.
`default_nettype none

module sbhs_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [sbhs_pkg::FUNC_W-1:0] req_func,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output sbhs_pkg::cmd_type                cmd,
   input  wire sbhs_pkg::sts_type           sts
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_OBS_CALC = 4'd1;
   localparam logic [3:0] S_OBS_RD1  = 4'd2;
   localparam logic [3:0] S_OBS_WR1  = 4'd3;
   localparam logic [3:0] S_OBS_RD2  = 4'd4;
   localparam logic [3:0] S_OBS_WR2  = 4'd5;
   localparam logic [3:0] S_CLR      = 4'd6;
   localparam logic [3:0] S_DRW_MUL0 = 4'd7;
   localparam logic [3:0] S_DRW_MUL1 = 4'd8;
   localparam logic [3:0] S_DRW_TGT  = 4'd9;
   localparam logic [3:0] S_DRW_WALK = 4'd10;
   localparam logic [3:0] S_DRW_DIV0 = 4'd11;
   localparam logic [3:0] S_DRW_DIV1 = 4'd12;
   localparam logic [3:0] S_DRW_DIV2 = 4'd13;
   localparam logic [3:0] S_DONE     = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_func)
                  sbhs_pkg::FUNC_OBSERVE: state_in = S_OBS_CALC;
                  sbhs_pkg::FUNC_DRAW:    state_in = S_DRW_MUL0;
                  sbhs_pkg::FUNC_CLEAR:   state_in = S_CLR;
                  default:                state_in = S_DONE;
               endcase
            end
         end
         S_OBS_CALC: begin
            cmd.obs_calc = 1'b1;
            state_in     = S_OBS_RD1;
         end
         S_OBS_RD1: begin
            cmd.rd_main = 1'b1;
            state_in    = S_OBS_WR1;
         end
         S_OBS_WR1: begin
            cmd.wr_main = 1'b1;
            state_in    = S_OBS_RD2;
         end
         S_OBS_RD2: begin
            cmd.rd_nbr = 1'b1;
            state_in   = S_OBS_WR2;
         end
         S_OBS_WR2: begin
            cmd.wr_nbr = 1'b1;
            state_in   = S_DONE;
         end
         S_CLR: begin
            cmd.clear = 1'b1;
            state_in  = S_DONE;
         end
         S_DRW_MUL0: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_DRW_MUL1;
         end
         S_DRW_MUL1: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_DRW_TGT;
         end
         S_DRW_TGT: begin
            cmd.tgt  = 1'b1;
            state_in = S_DRW_WALK;
         end
         S_DRW_WALK: begin
            // advance one bin per cycle until the cumulative weight covers the target or the bin is the last
            if (sts.walk_more) begin
               cmd.walk_step = 1'b1;
            end else begin
               state_in = S_DRW_DIV0;
            end
         end
         S_DRW_DIV0: begin
            cmd.div0 = 1'b1;
            state_in = S_DRW_DIV1;
         end
         S_DRW_DIV1: begin
            cmd.div1 = 1'b1;
            state_in = S_DRW_DIV2;
         end
         S_DRW_DIV2: begin
            cmd.div2 = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sbhs_dp.sv =====
// Datapath for the histogram sampler: weight memory, running total, draw
// target and walk, sample placement and result register. Depends on sbhs_pkg.
`default_nettype none

module sbhs_dp #(
   parameter int BINS = sbhs_pkg::BINS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sbhs_pkg::cmd_type               cmd,
   output sbhs_pkg::sts_type                    sts,
   input  wire logic [sbhs_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [sbhs_pkg::VALUE_W-1:0]    req_obs_value,
   input  wire logic [sbhs_pkg::VALUE_W-1:0]    req_rand_pick,
   input  wire logic [sbhs_pkg::VALUE_W-1:0]    req_rand_place,
   output logic [sbhs_pkg::VALUE_W-1:0]         rsp_sample,
   output logic [sbhs_pkg::BIN_OUT_W-1:0]       rsp_sample_bin
);

   localparam int VALUE_W   = sbhs_pkg::VALUE_W;
   localparam int WEIGHT_W  = sbhs_pkg::WEIGHT_W;
   localparam int TOTAL_W   = sbhs_pkg::TOTAL_W;
   localparam int SPLIT     = sbhs_pkg::TOTAL_SPLIT;
   localparam int BIN_W     = $clog2(BINS);
   localparam int NUM_W     = BIN_W + VALUE_W;
   localparam int CUM_W     = WEIGHT_W + BIN_W;
   localparam int TGT_W     = VALUE_W + TOTAL_W;
   localparam int CMP_W     = (TGT_W > CUM_W + VALUE_W) ? TGT_W : CUM_W + VALUE_W;
   localparam int LO_W      = VALUE_W + SPLIT;
   localparam int HI_W      = VALUE_W + TOTAL_W - SPLIT;
   localparam int DIV_K     = NUM_W;
   localparam int DPROD_W   = NUM_W + DIV_K;

   localparam logic [DIV_K-1:0]    RECIP       = DIV_K'((64'd1 << DIV_K) / BINS);
   localparam logic [NUM_W-1:0]    BINS_N      = NUM_W'(BINS);
   localparam logic [BIN_W-1:0]    BIN_LAST    = BIN_W'(BINS - 1);
   localparam logic [BIN_W:0]      BIN_LAST_X  = (BIN_W + 1)'(BINS - 1);
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = WEIGHT_W'(sbhs_pkg::ONE_Q16);
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = '1;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX   = '1;
   localparam logic [TOTAL_W-1:0]  TOTAL_RESET = TOTAL_W'(BINS) << VALUE_W;

   // captured transaction
   logic [sbhs_pkg::FUNC_W-1:0] func_ff;
   logic [VALUE_W-1:0]          obs_ff, pick_ff, place_ff;

   // observation working values
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [BIN_W-1:0]   nb_ff, nb_in;
   logic [VALUE_W-1:0] alpha_ff, alpha_in;
   logic [VALUE_W-1:0] obs_clamped, obs_frac;
   logic [NUM_W-1:0]   obs_prod;
   logic [BIN_W-1:0]   obs_bin;
   logic               obs_up;

   // weight memory and its read port
   logic [WEIGHT_W-1:0] weight_mem_ff [BINS];
   logic [BINS-1:0]     valid_ff;
   logic [WEIGHT_W-1:0] rdata_ff;
   logic                rvalid_ff;
   logic [WEIGHT_W-1:0] rd_word, wdata;
   logic [WEIGHT_W:0]   wsum;
   logic [VALUE_W:0]    add_amt;
   logic                rd_en, wr_en;
   logic [BIN_W-1:0]    rd_addr, wr_addr;
   logic [BIN_W:0]      pref_addr;
   logic                pref_ok;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W:0]   tsum;

   // draw
   logic [LO_W-1:0]    prod_lo_ff;
   logic [HI_W-1:0]    prod_hi_ff;
   logic [TGT_W-1:0]   target_ff;
   logic [CUM_W-1:0]   cum_ff, cum_in;
   logic [DPROD_W-1:0] div_prod_ff;
   logic [VALUE_W-1:0] q0_ff, q0_in, q_fix, sample_ff, sample_in;
   logic [NUM_W-1:0]   qb_ff, num, rem;

   logic [VALUE_W-1:0]            res_sample_ff, res_sample_in;
   logic [sbhs_pkg::BIN_OUT_W-1:0] res_bin_ff, res_bin_in;

   // ---- capture ----
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         obs_ff   <= req_obs_value;
         pick_ff  <= req_rand_pick;
         place_ff <= req_rand_place;
      end
   end

   // ---- observation: bin, neighbor and split weight ----
   always_comb begin
      obs_clamped = (obs_ff > sbhs_pkg::OBS_CLAMP) ? sbhs_pkg::OBS_CLAMP : obs_ff;
      // the clamp keeps the product below BINS, so the bin needs no clamp
      obs_prod    = NUM_W'(obs_clamped) * BINS_N;
      obs_bin     = obs_prod[NUM_W-1:VALUE_W];
      obs_frac    = obs_prod[VALUE_W-1:0];
      obs_up      = obs_frac > sbhs_pkg::HALF_Q16;
      alpha_in    = obs_up ? (obs_frac - sbhs_pkg::HALF_Q16)
                           : (sbhs_pkg::HALF_Q16 - obs_frac);
      if (obs_up) begin
         nb_in = (obs_bin == BIN_LAST) ? obs_bin : obs_bin + BIN_W'(1);
      end else begin
         nb_in = (obs_bin == '0) ? obs_bin : obs_bin - BIN_W'(1);
      end
   end

   always_comb begin
      bin_in = bin_ff;
      if (cmd.obs_calc) begin
         bin_in = obs_bin;
      end else if (cmd.mul_lo) begin
         bin_in = '0;
      end else if (cmd.walk_step) begin
         bin_in = bin_ff + BIN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      if (cmd.obs_calc) begin
         nb_ff    <= nb_in;
         alpha_ff <= alpha_in;
      end
   end

   // ---- weight memory; a never-written entry reads as 1.0 ----
   assign rd_word   = rvalid_ff ? rdata_ff : WEIGHT_ONE;
   assign pref_addr = {1'b0, bin_ff} + (BIN_W + 1)'(2);
   assign pref_ok   = pref_addr <= BIN_LAST_X;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = bin_ff;
      if (cmd.rd_main) begin
         rd_en = 1'b1;
      end else if (cmd.rd_nbr) begin
         rd_en   = 1'b1;
         rd_addr = nb_ff;
      end else if (cmd.mul_lo) begin
         rd_en   = 1'b1;
         rd_addr = BIN_W'(0);
      end else if (cmd.mul_hi) begin
         rd_en   = 1'b1;
         rd_addr = BIN_W'(1);
      end else if (cmd.walk_step) begin
         // prefetch the bin after the one being added
         rd_en   = pref_ok;
         rd_addr = pref_addr[BIN_W-1:0];
      end
   end

   always_comb begin
      wr_en   = cmd.wr_main | cmd.wr_nbr;
      wr_addr = cmd.wr_main ? bin_ff : nb_ff;
      add_amt = cmd.wr_main ? (sbhs_pkg::ONE_Q16 - {1'b0, alpha_ff}) : {1'b0, alpha_ff};
      wsum    = {1'b0, rd_word} + (WEIGHT_W + 1)'(add_amt);
      wdata   = wsum[WEIGHT_W] ? WEIGHT_MAX : wsum[WEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         weight_mem_ff[wr_addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= weight_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // ---- running total ----
   always_comb begin
      tsum     = {1'b0, total_ff} + (TOTAL_W + 1)'(sbhs_pkg::ONE_Q16);
      total_in = total_ff;
      if (cmd.clear) begin
         total_in = TOTAL_RESET;
      end else if (cmd.wr_nbr) begin
         total_in = tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
      end else begin
         total_ff <= total_in;
      end
   end

   // ---- draw: target in two partial products, then the walk ----
   always_comb begin
      cum_in = cum_ff;
      if (cmd.mul_hi) begin
         cum_in = CUM_W'(rd_word);
      end else if (cmd.walk_step) begin
         cum_in = cum_ff + CUM_W'(rd_word);
      end
   end

   always_ff @(posedge clock) begin
      cum_ff <= cum_in;
      if (cmd.mul_lo) begin
         prod_lo_ff <= LO_W'(pick_ff) * LO_W'(total_ff[SPLIT-1:0]);
      end
      if (cmd.mul_hi) begin
         prod_hi_ff <= HI_W'(pick_ff) * HI_W'(total_ff[TOTAL_W-1:SPLIT]);
      end
      if (cmd.tgt) begin
         target_ff <= (TGT_W'(prod_hi_ff) << SPLIT) + TGT_W'(prod_lo_ff);
      end
   end

   assign sts.walk_more = (CMP_W'(target_ff) > CMP_W'({cum_ff, {VALUE_W{1'b0}}}))
                          && (bin_ff != BIN_LAST);

   // ---- sample placement: (bin * 1.0 + place) / BINS by reciprocal ----
   assign num   = {bin_ff, place_ff};
   assign q0_in = div_prod_ff[DIV_K +: VALUE_W];
   assign rem   = num - qb_ff;

   always_comb begin
      // the estimate is low by at most one
      q_fix     = (rem >= BINS_N) ? q0_ff + VALUE_W'(1) : q0_ff;
      sample_in = (q_fix > sbhs_pkg::SAMPLE_CLAMP) ? sbhs_pkg::SAMPLE_CLAMP : q_fix;
   end

   always_ff @(posedge clock) begin
      if (cmd.div0) begin
         div_prod_ff <= DPROD_W'(num) * DPROD_W'(RECIP);
      end
      if (cmd.div1) begin
         q0_ff <= q0_in;
         qb_ff <= NUM_W'(q0_in) * BINS_N;
      end
      if (cmd.div2) begin
         sample_ff <= sample_in;
      end
   end

   // ---- result register ----
   always_comb begin
      case (func_ff)
         sbhs_pkg::FUNC_OBSERVE: begin
            res_sample_in = '0;
            res_bin_in    = sbhs_pkg::BIN_OUT_W'(bin_ff);
         end
         sbhs_pkg::FUNC_DRAW: begin
            res_sample_in = sample_ff;
            res_bin_in    = sbhs_pkg::BIN_OUT_W'(bin_ff);
         end
         default: begin
            res_sample_in = '0;
            res_bin_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         res_sample_ff <= res_sample_in;
         res_bin_ff    <= res_bin_in;
      end
   end

   assign rsp_sample     = res_sample_ff;
   assign rsp_sample_bin = res_bin_ff;

endmodule

`default_nettype wire

// ===== bench/sbhs_tb_pkg.sv =====
// Response scoreboard for the histogram sampler bench: keeps a mirror of the
// bin weights and total, predicts each response and checks the DUT against it.
// Depends on sbhs_pkg for widths, function codes and fixed-point constants.
package sbhs_tb_pkg;

   import sbhs_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int NBINS = BINS_DEFAULT;

   typedef struct packed {
      logic [VALUE_W-1:0]   sample;
      logic [BIN_OUT_W-1:0] bin;
   } sampler_reply_type;

   class hist_scoreboard_type;
      logic [WEIGHT_W-1:0] bin_weight [NBINS];
      logic [TOTAL_W-1:0]  weight_sum;
      sampler_reply_type   owed_replies [$];
      int unsigned         mismatches;
      int unsigned         replies_seen;
      int unsigned         func_count [4];

      function new();
         restore_uniform();
      endfunction

      function void restore_uniform();
         foreach (bin_weight[i]) bin_weight[i] = WEIGHT_W'(ONE_Q16);
         weight_sum = TOTAL_W'(NBINS) << 16;
      endfunction

      // Saturate each bin at all ones.
      function void add_to_bin(int unsigned idx, logic [VALUE_W:0] amount);
         logic [WEIGHT_W:0] sum;
         sum = {1'b0, bin_weight[idx]} + (WEIGHT_W + 1)'(amount);
         bin_weight[idx] = sum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum[WEIGHT_W-1:0];
      endfunction

      // Update the mirror for one accepted request and queue its response.
      function void note_request(logic [FUNC_W-1:0] fn, logic [VALUE_W-1:0] obs,
                                 logic [VALUE_W-1:0] pick, logic [VALUE_W-1:0] place);
         sampler_reply_type  due;
         logic [VALUE_W-1:0] v;
         logic [31:0]       prod;
         logic [VALUE_W-1:0] frac;
         logic [VALUE_W:0]  alpha;
         logic [TOTAL_W:0]  new_sum;
         logic [63:0]       target;
         logic [63:0]       cum;
         logic [63:0]       spot;
         int unsigned       idx;
         int unsigned       nbr;
         due = '0;
         func_count[fn]++;
         case (fn)
            FUNC_OBSERVE: begin
               v = (obs > OBS_CLAMP) ? OBS_CLAMP : obs;
               prod = 32'(v) * 32'(NBINS);
               idx = 32'(prod[31:16]);
               if (idx > NBINS - 1) idx = NBINS - 1;
               frac = prod[15:0];
               alpha = (frac > HALF_Q16) ? 17'(frac - HALF_Q16) : 17'(HALF_Q16 - frac);
               add_to_bin(idx, ONE_Q16 - alpha);
               // neighbor off either end folds back onto the bin itself
               if (frac > HALF_Q16) nbr = (idx + 1 < NBINS) ? idx + 1 : NBINS - 1;
               else nbr = (idx > 0) ? idx - 1 : 0;
               add_to_bin(nbr, alpha);
               new_sum = {1'b0, weight_sum} + (TOTAL_W + 1)'(ONE_Q16);
               weight_sum = new_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : new_sum[TOTAL_W-1:0];
               due.bin = BIN_OUT_W'(idx);
            end
            FUNC_DRAW: begin
               target = 64'(pick) * 64'(weight_sum);
               cum = 64'(bin_weight[0]);
               idx = 0;
               while (target > (cum << 16) && idx < NBINS - 1) begin
                  idx++;
                  cum += 64'(bin_weight[idx]);
               end
               spot = (64'(idx) * 64'(ONE_Q16) + 64'(place)) / 64'(NBINS);
               due.sample = (spot > 64'(SAMPLE_CLAMP)) ? SAMPLE_CLAMP : spot[VALUE_W-1:0];
               due.bin = BIN_OUT_W'(idx);
            end
            FUNC_CLEAR: restore_uniform();
            default: ;
         endcase
         owed_replies.push_back(due);
      endfunction

      function void report_mismatch(string what, sampler_reply_type due,
                                    sampler_reply_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH on response %0d (%s): expected sample=%0d bin=%0d, %s%0d bin=%0d",
                     replies_seen, what, due.sample, due.bin, "got sample=",
                     got.sample, got.bin);
      endfunction

      // Compare one accepted response with the oldest outstanding prediction.
      function void check_reply(logic [VALUE_W-1:0] sample, logic [BIN_OUT_W-1:0] bin);
         sampler_reply_type got;
         sampler_reply_type due;
         got.sample = sample;
         got.bin = bin;
         replies_seen++;
         if (owed_replies.size() == 0) begin
            report_mismatch("none outstanding", '0, got);
         end else begin
            due = owed_replies.pop_front();
            if (got.sample !== due.sample || got.bin !== due.bin)
               report_mismatch("field differs", due, got);
         end
      endfunction
   endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for soft_binned_histogram_sampler: clock, reset, request
// driver, response sink with back-pressure, monitor, watchdog and stimulus.
// Depends on sbhs_pkg and sbhs_tb_pkg (scoreboard and mirror of the bins).
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sbhs_pkg::*;
   import sbhs_tb_pkg::*;

   // Longest quiet stretch in a correct run is the forced hold-off plus one
   // full draw walk; allow several times that.
   localparam int QUIET_LIMIT     = 3000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 560;
   localparam int DRAIN_CYCLES    = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [FUNC_W-1:0]    req_func;
   logic [VALUE_W-1:0]   req_obs_value;
   logic [VALUE_W-1:0]   req_rand_pick;
   logic [VALUE_W-1:0]   req_rand_place;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [VALUE_W-1:0]   rsp_sample;
   logic [BIN_OUT_W-1:0] rsp_sample_bin;

   // Idle odds in percent, set per phase by the stimulus process.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   // Cycles the response sink still has to hold rsp_ready low.
   int unsigned hold_off_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned input_stall_cycles = 0;

   hist_scoreboard_type board;

   soft_binned_histogram_sampler #(.BINS(NBINS)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_obs_value  (req_obs_value),
      .req_rand_pick  (req_rand_pick),
      .req_rand_place (req_rand_place),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample     (rsp_sample),
      .rsp_sample_bin (rsp_sample_bin)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one transaction: drive at the falling edge, optionally idle first,
   // then hold valid and payload until a rising edge sees ready high.
   task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] obs,
                               input logic [VALUE_W-1:0] pick,
                               input logic [VALUE_W-1:0] place);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= fn;
      req_obs_value  <= obs;
      req_rand_pick  <= pick;
      req_rand_place <= place;
      do @(posedge clock); while (!req_ready);
   endtask

   // Mostly observe/draw traffic so the weights drift far from uniform between
   // the occasional clears; a slice of each field is steered to its corners.
   task automatic send_random_request();
      int unsigned        roll;
      logic [FUNC_W-1:0]  fn;
      logic [VALUE_W-1:0] obs;
      logic [VALUE_W-1:0] pick;
      logic [VALUE_W-1:0] place;
      roll = $urandom_range(99);
      if (roll < 50) fn = FUNC_OBSERVE;
      else if (roll < 94) fn = FUNC_DRAW;
      else if (roll < 97) fn = FUNC_UNUSED;
      else fn = FUNC_CLEAR;
      obs   = VALUE_W'($urandom);
      pick  = VALUE_W'($urandom);
      place = VALUE_W'($urandom);
      case ($urandom_range(9))
         0: obs = VALUE_W'($urandom_range(OBS_CLAMP, 16'hFFFF)); // at or above the observe clamp
         1: obs = VALUE_W'($urandom_range(2730));                // low half of bin 0
         2, 3: obs = VALUE_W'($urandom_range(16'h0FFF));         // pile weight on low bins
         4: pick = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         5: begin                                                // deep walk, clamped sample
            pick  = 16'hFFFF - VALUE_W'($urandom_range(255));
            place = 16'hFFFF - VALUE_W'($urandom_range(255));
         end
         default: ;
      endcase
      send_request(fn, obs, pick, place);
   endtask

   // Response sink: a pending hold-off wins, otherwise idle at the phase odds.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left != 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Monitor: record every handshake at the rising edge. Note the request
   // first so a response in the same cycle still pops the oldest prediction.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_valid && req_ready)
               board.note_request(req_func, req_obs_value, req_rand_pick, req_rand_place);
            if (rsp_valid && rsp_ready)
               board.check_reply(rsp_sample, rsp_sample_bin);
            if (req_valid && !req_ready)
               input_stall_cycles++;
         end
      end
   end

   // Watchdog: end the run if no transaction moves on either channel for too long.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Watchdog: no transaction for %0d cycles, %0d responses outstanding",
               QUIET_LIMIT, board.owed_replies.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      board          = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_OBSERVE;
      req_obs_value  = '0;
      req_rand_pick  = '0;
      req_rand_place = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one: sender idles lightly, receiver heavily.
      send_idle_pct = 35;
      recv_idle_pct = 47;

      // Directed corners on the uniform reset histogram first.
      send_request(FUNC_DRAW, '0, 16'h0000, 16'h0000);      // first bin, zero sample
      send_request(FUNC_DRAW, '0, 16'hFFFF, 16'hFFFF);      // walk to last bin, clamp
      send_request(FUNC_DRAW, '0, 16'h8000, 16'h8000);
      // Observations: both edge neighbors, the observe clamp, exact centre,
      // and values just either side of bin boundaries.
      send_request(FUNC_OBSERVE, 16'h0000, '0, '0);
      send_request(FUNC_OBSERVE, 16'hFFFF, '0, '0);
      send_request(FUNC_OBSERVE, OBS_CLAMP, '0, '0);
      send_request(FUNC_OBSERVE, 16'd8192, '0, '0);
      send_request(FUNC_OBSERVE, 16'd2731, '0, '0);
      send_request(FUNC_OBSERVE, 16'd5461, '0, '0);
      send_request(FUNC_OBSERVE, 16'd5462, '0, '0);
      send_request(FUNC_OBSERVE, 16'd60074, '0, '0);
      send_request(FUNC_OBSERVE, 16'd60075, '0, '0);
      // Unused function code must leave the state alone.
      send_request(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_UNUSED, 16'h0000, 16'h0000, 16'h0000);
      // Draws over the skewed histogram.
      send_request(FUNC_DRAW, '0, 16'hFFFF, 16'h0000);
      send_request(FUNC_DRAW, '0, 16'h0001, 16'h0001);
      send_request(FUNC_DRAW, '0, 16'h0000, 16'hFFFF);
      // Clear, then confirm uniform behavior is back.
      send_request(FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_DRAW, '0, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_DRAW, '0, 16'h7FFF, 16'h0000);

      repeat (ITEMS_PER_PHASE) send_random_request();

      // Phase two: swap the idle odds.
      send_idle_pct = 47;
      recv_idle_pct = 35;
      repeat (ITEMS_PER_PHASE) send_random_request();

      // Phase three: no idling. Open with a long receiver hold-off while the
      // sender keeps offering, so the output register fills and req_ready drops.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (ITEMS_PER_PHASE) send_random_request();

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain outstanding responses; the watchdog bounds this wait.
      while (board.owed_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d observe, %0d draw, %0d clear and %0d unused-code transactions",
               board.func_count[FUNC_OBSERVE], board.func_count[FUNC_DRAW],
               board.func_count[FUNC_CLEAR], board.func_count[FUNC_UNUSED]);
      $display("%0d responses checked, %0d mismatches, request held off for %0d cycles",
               board.replies_seen, board.mismatches, input_stall_cycles);
      if (board.mismatches == 0 && board.owed_replies.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
